// ===== rtl/box_downsample_2x2_rgb_defines.svh =====
// Assertion macros used by the checker file of the 2x2 box downsampler.
// Depends on nothing; included by file name where assertions are written.
`ifndef BOX_DOWNSAMPLE_2X2_RGB_DEFINES_SVH
`define BOX_DOWNSAMPLE_2X2_RGB_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bds: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bds: next-cycle check failed");

`endif

// ===== rtl/bds_pkg.sv =====
// Types and fixed widths of the 2x2 box downsampler.
// No dependencies; used by the interfaces, the line store and the top level.
`default_nettype none

package bds_pkg;

	localparam int PIX_W     = 8;
	localparam int PAIR_W    = 9;
	localparam int SUM_W     = 10;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int COORD_W   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] SIZE_RESET = 12'd256;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic [PAIR_W-1:0] blue;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] red;
	} pair_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} store_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bds_stream_if.sv =====
// Valid/ready stream interfaces for source pixels and averaged output pixels.
// Depends on bds_pkg for the field widths.
`default_nettype none

interface bds_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bds_pkg::PIX_W-1:0] in_red;
	logic [bds_pkg::PIX_W-1:0] in_green;
	logic [bds_pkg::PIX_W-1:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface bds_avg_if;
	logic                        valid;
	logic                        ready;
	logic [bds_pkg::PIX_W-1:0]   avg_red;
	logic [bds_pkg::PIX_W-1:0]   avg_green;
	logic [bds_pkg::PIX_W-1:0]   avg_blue;
	logic [bds_pkg::COORD_W-1:0] out_col;
	logic [bds_pkg::COORD_W-1:0] out_row;
	logic                        last_of_level;

	modport source (output valid, output avg_red, output avg_green, output avg_blue,
		output out_col, output out_row, output last_of_level, input ready);
	modport sink (input valid, input avg_red, input avg_green, input avg_blue,
		input out_col, input out_row, input last_of_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/bds_line_store.sv =====
// Single-port line store holding the pair sums of the even row, one entry per block.
// Depends on bds_pkg for the entry and control types.
`default_nettype none

module bds_line_store #(
	parameter int DEPTH = 1024
) (
	input  wire                                  clk,
	input  bds_pkg::store_ctl_t                  ctl,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  bds_pkg::pair_t                       wdata,
	output bds_pkg::pair_t                       rdata
);

	bds_pkg::pair_t mem [DEPTH];
	bds_pkg::pair_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/box_downsample_2x2_rgb.sv =====
// Top level of the 2x2 box downsampler: counters, pair sums, line store, output stage.
// Depends on bds_pkg, bds_stream_if and bds_line_store.
//
// Usage: source pixels arrive as beats on the pixels channel in raster order.
// Each pixel at an odd column of an odd row closes a 2x2 block, and one beat
// with the truncated per-channel mean, its level coordinates and a last flag
// leaves on the level channel in the cycle after that pixel is accepted.
// Throughput is one pixel per clock while the output stage can take a beat: the line
// store has a single port and is touched at most once per pixel, written on even rows
// and read on odd rows, so a read never meets a pending write of the same entry.
// Writing either size register through the configuration port restarts the frame
// at column 0, row 0; the user makes writes while the block is idle (unenforced).
// Reset sets both sizes to 256 and clears the counters and the held pixel;
// the line store is not cleared, since every entry is written by an even row
// before the odd row below reads it.
// When the receiver stalls, the finished beat waits in the output stage.
// Pixels that complete no block are still accepted meanwhile; a pixel that
// would complete the next block waits until the held beat is taken.
`default_nettype none

module box_downsample_2x2_rgb #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [bds_pkg::CFG_W-1:0]         cfg_data,
	bds_pix_if.sink                          pixels,
	bds_avg_if.source                        level
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = ($clog2(MAX_WIDTH + 1) > bds_pkg::CFG_W) ?
		$clog2(MAX_WIDTH + 1) : bds_pkg::CFG_W;
	localparam int HW    = ($clog2(MAX_HEIGHT + 1) > bds_pkg::CFG_W) ?
		$clog2(MAX_HEIGHT + 1) : bds_pkg::CFG_W;
	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [bds_pkg::CFG_W-1:0]   src_width_q;
	logic [bds_pkg::CFG_W-1:0]   src_height_q;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	bds_pkg::pix_t               held_q;

	logic                        v_s1;
	bds_pkg::pair_t              pair_s1;
	logic [bds_pkg::COORD_W-1:0] ocol_s1;
	logic [bds_pkg::COORD_W-1:0] orow_s1;
	logic                        last_s1;

	logic [WW-1:0]               w_ext;
	logic [WW-1:0]               w_eff;
	logic [HW-1:0]               h_ext;
	logic [HW-1:0]               h_eff;
	logic                        gen;
	logic                        in_ready;
	logic                        acc;
	logic                        col_end;
	logic                        row_end;
	logic                        last_now;
	logic                        cfg_size;
	bds_pkg::pix_t               pix;
	bds_pkg::pair_t              pair;
	bds_pkg::pair_t              upper;
	bds_pkg::store_ctl_t         st_ctl;
	logic [bds_pkg::SUM_W-1:0]   sum_r;
	logic [bds_pkg::SUM_W-1:0]   sum_g;
	logic [bds_pkg::SUM_W-1:0]   sum_b;

	always_comb begin
		w_ext = WW'(src_width_q);
		if (w_ext < WW'(2)) begin
			w_eff = WW'(2);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_ext = HW'(src_height_q);
		if (h_ext < HW'(2)) begin
			h_eff = HW'(2);
		end else if (h_ext > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
	end

	assign pix.red   = pixels.in_red;
	assign pix.green = pixels.in_green;
	assign pix.blue  = pixels.in_blue;

	assign gen      = col_q[0] & row_q[0];
	assign in_ready = !gen || !v_s1 || level.ready;
	assign acc      = pixels.valid && in_ready;
	assign pixels.ready = in_ready;

	assign col_end  = WW'(col_q) >= (w_eff - WW'(1));
	assign row_end  = HW'(row_q) >= (h_eff - HW'(1));
	assign last_now = (WW'(col_q >> 1) == ((w_eff >> 1) - WW'(1))) &&
		(HW'(row_q >> 1) == ((h_eff >> 1) - HW'(1)));
	assign cfg_size = cfg_we && (cfg_index == bds_pkg::REG_SOURCE_WIDTH ||
		cfg_index == bds_pkg::REG_SOURCE_HEIGHT);

	assign pair.red   = bds_pkg::PAIR_W'(held_q.red) + bds_pkg::PAIR_W'(pix.red);
	assign pair.green = bds_pkg::PAIR_W'(held_q.green) + bds_pkg::PAIR_W'(pix.green);
	assign pair.blue  = bds_pkg::PAIR_W'(held_q.blue) + bds_pkg::PAIR_W'(pix.blue);

	assign st_ctl.wr = acc && col_q[0] && !row_q[0];
	assign st_ctl.rd = acc && gen;

	bds_line_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.ctl  (st_ctl),
		.addr (AW'(col_q >> 1)),
		.wdata(pair),
		.rdata(upper)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bds_pkg::SIZE_RESET;
			src_height_q <= bds_pkg::SIZE_RESET;
			col_q        <= '0;
			row_q        <= '0;
			held_q       <= '0;
			v_s1         <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == bds_pkg::REG_SOURCE_WIDTH) begin
				src_width_q <= cfg_data;
			end
			if (cfg_we && cfg_index == bds_pkg::REG_SOURCE_HEIGHT) begin
				src_height_q <= cfg_data;
			end
			if (cfg_size) begin
				col_q <= '0;
				row_q <= '0;
			end else if (acc) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (acc && !col_q[0]) begin
				held_q <= pix;
			end
			if (acc && gen) begin
				v_s1 <= 1'b1;
			end else if (level.ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && gen) begin
			pair_s1 <= pair;
			ocol_s1 <= bds_pkg::COORD_W'(col_q >> 1);
			orow_s1 <= bds_pkg::COORD_W'(row_q >> 1);
			last_s1 <= last_now;
		end
	end

	assign sum_r = bds_pkg::SUM_W'(pair_s1.red) + bds_pkg::SUM_W'(upper.red);
	assign sum_g = bds_pkg::SUM_W'(pair_s1.green) + bds_pkg::SUM_W'(upper.green);
	assign sum_b = bds_pkg::SUM_W'(pair_s1.blue) + bds_pkg::SUM_W'(upper.blue);

	assign level.valid         = v_s1;
	assign level.avg_red       = sum_r[bds_pkg::SUM_W-1:2];
	assign level.avg_green     = sum_g[bds_pkg::SUM_W-1:2];
	assign level.avg_blue      = sum_b[bds_pkg::SUM_W-1:2];
	assign level.out_col       = ocol_s1;
	assign level.out_row       = orow_s1;
	assign level.last_of_level = last_s1;

endmodule

`default_nettype wire

// ===== rtl/bds_checker.sv =====
// Port-level checks of the 2x2 box downsampler, bound to the top level.
// Depends on bds_pkg and the assertion macros in box_downsample_2x2_rgb_defines.svh.
`default_nettype none
`include "box_downsample_2x2_rgb_defines.svh"

module bds_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_ready,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire [bds_pkg::PIX_W-1:0]         avg_red,
	input wire [bds_pkg::PIX_W-1:0]         avg_green,
	input wire [bds_pkg::PIX_W-1:0]         avg_blue,
	input wire [bds_pkg::COORD_W-1:0]       out_col,
	input wire [bds_pkg::COORD_W-1:0]       out_row,
	input wire                              last_of_level
);

	// A stalled output beat keeps its payload.
	`BDS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(avg_red) && $stable(avg_green) && $stable(avg_blue) && $stable(out_col) && $stable(out_row) && $stable(last_of_level))

	// A new output beat is always caused by a pixel accepted in the cycle before.
	`BDS_ASSERT_NOW(a_out_cause, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready))

	// A beat that is taken while no pixel enters leaves the output stage empty.
	`BDS_ASSERT_NEXT(a_out_drain, clk, arst_n, out_valid && out_ready && !(in_valid && in_ready), !out_valid)

	// The input is never refused while the output stage is free.
	`BDS_ASSERT_NOW(a_in_free, clk, arst_n, !out_valid, in_ready)

endmodule

bind box_downsample_2x2_rgb bds_checker u_bds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixels.valid),
	.in_ready     (pixels.ready),
	.out_valid    (level.valid),
	.out_ready    (level.ready),
	.avg_red      (level.avg_red),
	.avg_green    (level.avg_green),
	.avg_blue     (level.avg_blue),
	.out_col      (level.out_col),
	.out_row      (level.out_row),
	.last_of_level(level.last_of_level)
);

`default_nettype wire

// ===== tb/tb_box_downsample_2x2_rgb.sv =====
`timescale 1ns / 100ps
// Testbench of box_downsample_2x2_rgb: directed and random RGB frames go in as pixel beats,
// and every level beat is checked against a local prediction of the 2x2 box average.
// Depends on bds_pkg, the bds_pix_if and bds_avg_if interfaces and the RTL top level.

module tb_box_downsample_2x2_rgb;

	localparam int MAX_W        = 2048;
	localparam int MAX_H        = 2048;
	localparam int STORE_DEPTH  = MAX_W / 2;
	localparam int TOTAL_PIXELS = 1900;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX   = 10;

	localparam logic [bds_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bds_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [bds_pkg::PIX_W-1:0]   red, green, blue;
		logic [bds_pkg::COORD_W-1:0] col, row;
		logic                        last;
	} level_pix_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bds_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bds_pkg::CFG_W-1:0]     cfg_data;

	bds_pix_if pix_ch ();
	bds_avg_if lvl_ch ();

	box_downsample_2x2_rgb #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pix_ch),
		.level    (lvl_ch)
	);

	// Predicted state of the block, updated only by the pixel driver.
	logic [bds_pkg::CFG_W-1:0] size_w_reg = bds_pkg::SIZE_RESET;
	logic [bds_pkg::CFG_W-1:0] size_h_reg = bds_pkg::SIZE_RESET;
	logic [10:0]               col_cnt    = '0;
	logic [10:0]               row_cnt    = '0;
	bds_pkg::pix_t             left_pixel = '0;
	bds_pkg::pair_t            upper_sums [STORE_DEPTH];

	bds_pkg::pix_t pending_pixels [$];
	level_pix_t    expected_avgs [$];

	int mismatches  = 0;
	int cycle_count = 0;
	int hold_req    = 0;
	int pixels_sent = 0;

	function automatic int eff_size(input int v, input int maxv);
		if (v < 2)
			return 2;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic void predict_config(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
		input logic [bds_pkg::CFG_W-1:0] val);
		case (idx)
			bds_pkg::REG_SOURCE_WIDTH: begin
				size_w_reg = val;
				col_cnt    = '0;
				row_cnt    = '0;
			end
			bds_pkg::REG_SOURCE_HEIGHT: begin
				size_h_reg = val;
				col_cnt    = '0;
				row_cnt    = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_pixel(input bds_pkg::pix_t p);
		int                        w;
		int                        h;
		bds_pkg::pair_t            pr;
		bds_pkg::pair_t            up;
		level_pix_t                e;
		logic [bds_pkg::SUM_W-1:0] sr;
		logic [bds_pkg::SUM_W-1:0] sg;
		logic [bds_pkg::SUM_W-1:0] sb;
		w = eff_size(int'(size_w_reg), MAX_W);
		h = eff_size(int'(size_h_reg), MAX_H);
		if (!col_cnt[0]) begin
			left_pixel = p;
		end else begin
			pr.red   = bds_pkg::PAIR_W'(left_pixel.red) + bds_pkg::PAIR_W'(p.red);
			pr.green = bds_pkg::PAIR_W'(left_pixel.green) + bds_pkg::PAIR_W'(p.green);
			pr.blue  = bds_pkg::PAIR_W'(left_pixel.blue) + bds_pkg::PAIR_W'(p.blue);
			if (!row_cnt[0]) begin
				upper_sums[col_cnt[10:1]] = pr;
			end else begin
				up      = upper_sums[col_cnt[10:1]];
				sr      = bds_pkg::SUM_W'(pr.red) + bds_pkg::SUM_W'(up.red);
				sg      = bds_pkg::SUM_W'(pr.green) + bds_pkg::SUM_W'(up.green);
				sb      = bds_pkg::SUM_W'(pr.blue) + bds_pkg::SUM_W'(up.blue);
				e.red   = sr[bds_pkg::SUM_W-1:2];
				e.green = sg[bds_pkg::SUM_W-1:2];
				e.blue  = sb[bds_pkg::SUM_W-1:2];
				e.col   = col_cnt[10:1];
				e.row   = row_cnt[10:1];
				e.last  = (int'(e.col) == w / 2 - 1) && (int'(e.row) == h / 2 - 1);
				expected_avgs.push_back(e);
			end
		end
		if (int'(col_cnt) + 1 >= w) begin
			col_cnt = '0;
			row_cnt = (int'(row_cnt) + 1 >= h) ? '0 : row_cnt + 11'd1;
		end else begin
			col_cnt = col_cnt + 11'd1;
		end
	endfunction

	function automatic bds_pkg::pix_t random_pixel();
		logic [23:0]   r;
		bds_pkg::pix_t p;
		r = 24'($urandom);
		p = r;
		case ($urandom_range(0, 9))
			0: p = '0;
			1: p = '1;
			default: ;
		endcase
		return p;
	endfunction

	function automatic bds_pkg::pix_t mk_pix(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		bds_pkg::pix_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		return p;
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 11))
			0: return $urandom_range(0, 1);
			1: return $urandom_range(9, 40);
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	function automatic string beat_text(input level_pix_t b);
		return $sformatf("r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
			b.red, b.green, b.blue, b.col, b.row, b.last);
	endfunction

	function automatic void flag_beat(input string what, input level_pix_t got,
		input level_pix_t want);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%s: expected %s, got %s", what, beat_text(want), beat_text(got));
	endfunction

	task automatic write_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
		input logic [bds_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_random(input int n);
		@(negedge clk);
		repeat (n)
			pending_pixels.push_back(random_pixel());
		pixels_sent += n;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || pix_ch.valid || expected_avgs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_box_downsample_2x2_rgb NOT OK");
			$finish;
		end
	end

	// Pixel sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin : pixel_driver
		int            burst_left;
		int            gap_left;
		bds_pkg::pix_t next_px;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (cfg_we)
				predict_config(cfg_index, cfg_data);
			if (pix_ch.valid && pix_ch.ready)
				predict_pixel({pix_ch.in_blue, pix_ch.in_green, pix_ch.in_red});
			if (!(pix_ch.valid && !pix_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_ch.valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					next_px = pending_pixels.pop_front();
					pix_ch.valid    <= 1'b1;
					pix_ch.in_red   <= next_px.red;
					pix_ch.in_green <= next_px.green;
					pix_ch.in_blue  <= next_px.blue;
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
							: $urandom_range(1, 40);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Level receiver: stall pattern changes over time; a hold-off request stalls it for long.
	always @(posedge clk) begin : level_ready
		int       hold_seen;
		int       hold_left;
		int       mode_left;
		int       mode_cnt;
		rx_mode_t mode;
		if (!arst_n) begin
			lvl_ch.ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			mode_left = 0;
			mode_cnt  = 0;
			mode      = RX_ALWAYS;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = $urandom_range(300, 500);
			end
			if (hold_left > 0) begin
				hold_left--;
				lvl_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
					mode_cnt  = 0;
				end
				mode_left--;
				mode_cnt++;
				case (mode)
					RX_ALWAYS:   lvl_ch.ready <= 1'b1;
					RX_COIN:     lvl_ch.ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: lvl_ch.ready <= (mode_cnt % 7) < 4;
					default:     lvl_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : level_monitor
		level_pix_t got;
		level_pix_t want;
		if (arst_n && lvl_ch.valid && lvl_ch.ready) begin
			got = {lvl_ch.avg_red, lvl_ch.avg_green, lvl_ch.avg_blue,
				lvl_ch.out_col, lvl_ch.out_row, lvl_ch.last_of_level};
			if (expected_avgs.size() == 0) begin
				flag_beat("level beat with nothing expected", got, '0);
			end else begin
				want = expected_avgs.pop_front();
				if (got !== want)
					flag_beat("level beat mismatch", got, want);
			end
		end
	end

	initial begin : stimulus
		int w_val;
		int h_val;
		int frame_px;
		int n_px;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = bds_pkg::REG_SOURCE_WIDTH;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset size: two full rows and part of the next even row, with a long stall.
		queue_random(520);
		hold_req <= hold_req + 1;
		wait_idle();

		// Smallest image: saturated, empty and truncating blocks.
		write_reg(bds_pkg::REG_SOURCE_WIDTH, 12'd2);
		write_reg(bds_pkg::REG_SOURCE_HEIGHT, 12'd2);
		@(negedge clk);
		repeat (4) pending_pixels.push_back(mk_pix(8'hff, 8'hff, 8'hff));
		repeat (4) pending_pixels.push_back(mk_pix(8'h00, 8'h00, 8'h00));
		repeat (3) pending_pixels.push_back(mk_pix(8'hff, 8'h00, 8'h01));
		pending_pixels.push_back(mk_pix(8'hfe, 8'h03, 8'h00));
		pixels_sent += 12;
		wait_idle();

		// Odd sizes drop the trailing column and row; spare indexes must not restart the frame.
		write_reg(bds_pkg::REG_SOURCE_WIDTH, 12'd3);
		write_reg(bds_pkg::REG_SOURCE_HEIGHT, 12'd3);
		queue_random(5);
		wait_idle();
		write_reg(REG_SPARE_2, 12'd0);
		write_reg(REG_SPARE_3, 12'hfff);
		queue_random(9);
		wait_idle();

		// Oversized width and undersized height are clamped; the first row yields no beat.
		write_reg(bds_pkg::REG_SOURCE_WIDTH, 12'hfff);
		write_reg(bds_pkg::REG_SOURCE_HEIGHT, 12'd0);
		queue_random(64);

		while (pixels_sent < TOTAL_PIXELS) begin
			wait_idle();
			w_val = pick_size();
			h_val = (w_val > 12) ? $urandom_range(0, 4) : pick_size();
			case ($urandom_range(0, 3))
				0: begin
					write_reg(bds_pkg::REG_SOURCE_WIDTH, bds_pkg::CFG_W'(w_val));
					write_reg(bds_pkg::REG_SOURCE_HEIGHT, bds_pkg::CFG_W'(h_val));
				end
				1: begin
					write_reg(bds_pkg::REG_SOURCE_HEIGHT, bds_pkg::CFG_W'(h_val));
					write_reg(bds_pkg::REG_SOURCE_WIDTH, bds_pkg::CFG_W'(w_val));
				end
				2: write_reg(bds_pkg::REG_SOURCE_WIDTH, bds_pkg::CFG_W'(w_val));
				default: write_reg(bds_pkg::REG_SOURCE_HEIGHT, bds_pkg::CFG_W'(h_val));
			endcase
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					bds_pkg::CFG_W'($urandom));
			frame_px = eff_size(int'(size_w_reg), MAX_W) * eff_size(int'(size_h_reg), MAX_H);
			n_px = $urandom_range(1, 3) * frame_px;
			if ($urandom_range(0, 2) == 0)
				n_px += $urandom_range(1, frame_px - 1);
			queue_random(n_px);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_avgs.size() == 0)
			$display("tb_box_downsample_2x2_rgb OK");
		else
			$display("tb_box_downsample_2x2_rgb NOT OK");
		$finish;
	end

endmodule
